### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the primality tester.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TDPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdpt: assertion failed");

// Clocked assertion that is also checked during reset.
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tdpt: reset assertion failed");

`endif

### rtl/core/tdpt_pkg.sv
// Package with the shared types and constants of the trial-division primality tester.
package tdpt_pkg;

    // Default width of the tested value.
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the result stream data: one flag padded to a byte.
    localparam int OUT_TDATA_W = 8;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

endpackage

### rtl/core/tdpt_div.sv
// Restoring radix-2 divider that yields quotient and remainder, one bit per cycle.
module tdpt_div #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);

    localparam int CntWidth = $clog2(VALUE_WIDTH + 1);

    logic [CntWidth-1:0]    r_cnt, n_cnt;
    logic                   r_done, n_done;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_dsr, n_dsr;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    always_comb begin
        // The partial remainder takes the next dividend bit, then the divisor is tried.
        shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
        trial   = shifted - {1'b0, r_dsr};
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_cnt = CntWidth'(VALUE_WIDTH);
            n_rem = '0;
            n_quo = i_dividend;
            n_dsr = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CntWidth'(1);
            n_done = (r_cnt == CntWidth'(1));
            if (!trial[VALUE_WIDTH]) begin
                n_rem = trial[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = shifted[VALUE_WIDTH-1:0];
                n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### rtl/core/trial_division_prime_test_top.sv
// Top level of the trial-division primality tester with its sequencer.
//
// The block takes one signed VALUE_WIDTH-bit candidate per request and answers with one
// request carrying a single is_prime flag. Negative values, zero and one give 0, two and
// three give 1, and even values above two give 0, all without any division. Such a result
// passes from ST_FINISH into the output register, where ST_FINISH waits as long as an
// earlier result is still held there. Odd candidates of five or more are divided by 3, 5,
// 7 and so on by one shared restoring divider that produces one quotient bit per cycle,
// one full division per trial divisor. The search stops with 0 on the first zero remainder
// and with 1 as soon as the divisor exceeds the quotient, that is once the divisor squared
// exceeds the candidate. A prime p therefore runs (floor(sqrt(p)) + 1) / 2 trials, rounded
// down; for 32 bits the worst case is 23170 trials. The input side is ready only while the
// sequencer is idle, one candidate at a time. The result sits in an output register, so
// the next candidate may be accepted while an earlier result still waits to be taken.
module trial_division_prime_test_top #(
    parameter int  VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
    localparam int InTdataW    = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [InTdataW-1:0]              i_s_axis_tdata,  // [VALUE_WIDTH-1:0] candidate
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [tdpt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] is_prime
);

    localparam int CmpWidth = VALUE_WIDTH + 2;

    tdpt_pkg::t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] r_dsr, n_dsr;
    logic                   r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_data, n_out_data;

    logic                   in_accept;
    logic [VALUE_WIDTH-1:0] cand;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    // Bits of the request data above the value width are ignored.
    assign cand      = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    tdpt_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (n_value),
        .i_divisor   (n_dsr),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_value    <= n_value;
        r_dsr      <= n_dsr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_dsr       = r_dsr;
        n_res       = r_res;
        div_start   = 1'b0;
        // A waiting result is dropped from the register once the downstream side takes it.
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_value = cand;
                    n_state = tdpt_pkg::ST_FINISH;
                    if (cand[VALUE_WIDTH-1] || (cand[VALUE_WIDTH-1:1] == '0)) begin
                        // Negative, zero or one.
                        n_res = 1'b0;
                    end else if ({2'b00, cand} < CmpWidth'(4)) begin
                        // Two or three.
                        n_res = 1'b1;
                    end else if (!cand[0]) begin
                        n_res = 1'b0;
                    end else begin
                        n_dsr     = VALUE_WIDTH'(3);
                        div_start = 1'b1;
                        n_state   = tdpt_pkg::ST_DIVIDE;
                    end
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    if (r_dsr > div_quo) begin
                        // Divisor squared is past the candidate: no factor exists.
                        n_res   = 1'b1;
                        n_state = tdpt_pkg::ST_FINISH;
                    end else if (div_rem == '0) begin
                        n_res   = 1'b0;
                        n_state = tdpt_pkg::ST_FINISH;
                    end else begin
                        n_dsr     = r_dsr + VALUE_WIDTH'(2);
                        div_start = 1'b1;
                    end
                end
            end
            tdpt_pkg::ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == tdpt_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tdpt_pkg::OUT_TDATA_W - 1){1'b0}}, r_out_data};

endmodule

### rtl/core/tdpt_checker.sv
// Port-level checker for the primality tester, bound to its top level.
`include "assert_macros.svh"

module tdpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [tdpt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // No result is pending right after reset.
    `TDPT_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

    // A stalled result keeps its value.
    `TDPT_ASSERT(a_out_hold, i_clk, i_rst_n,
                 o_m_axis_tvalid && !i_m_axis_tready |=>
                     o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Once a candidate is taken the block works on it and takes no other.
    `TDPT_ASSERT(a_one_at_a_time, i_clk, i_rst_n,
                 i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)

    // A new result only appears when the input side has just been busy.
    `TDPT_ASSERT(a_result_after_work, i_clk, i_rst_n,
                 $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
